>>> src/pnpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnpr_pkg
// Shared types and constants of the nearest path point reference block:
// field widths, stream packing offsets, codes, controller commands and status.
// ----------------------------------------------------------------------------
package pnpr_pkg;

   // Field widths
   localparam int unsigned COORD_W   = 32;
   localparam int unsigned INDEX_W   = 10;
   localparam int unsigned ACCEL_W   = 18;
   localparam int unsigned MAG_W     = 17;
   localparam int unsigned LEN_CFG_W = 11;

   // Configuration port
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   // Request stream packing (tdata, lowest bit first)
   localparam int unsigned REQ_TDATA_W   = 216;
   localparam int unsigned REQ_TUSER_W   = 1;
   localparam int unsigned REQ_IDX_LSB   = 0;
   localparam int unsigned REQ_PX_LSB    = 10;
   localparam int unsigned REQ_PY_LSB    = 42;
   localparam int unsigned REQ_PYAW_LSB  = 74;
   localparam int unsigned REQ_PSPD_LSB  = 106;
   localparam int unsigned REQ_VX_LSB    = 138;
   localparam int unsigned REQ_VY_LSB    = 170;
   localparam int unsigned REQ_PREV_LSB  = 202;

   // Response stream packing (tdata, lowest bit first)
   localparam int unsigned RSP_TDATA_W   = 160;
   localparam int unsigned RSP_X_LSB     = 0;
   localparam int unsigned RSP_Y_LSB     = 32;
   localparam int unsigned RSP_SPD_LSB   = 64;
   localparam int unsigned RSP_YAW_LSB   = 96;
   localparam int unsigned RSP_ACC_LSB   = 128;
   localparam int unsigned RSP_TGT_LSB   = 146;

   // Operation codes carried in req_tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Register indexes (paddr bit 2)
   localparam logic CSR_IDX_COURSE_LENGTH = 1'b0;
   localparam logic CSR_IDX_ACCEL_MAG     = 1'b1;

   // Register reset values and limits
   localparam logic [LEN_CFG_W-1:0] COURSE_LENGTH_RESET = 11'd1;
   localparam logic [MAG_W-1:0]     ACCEL_MAG_RESET     = 17'd6554;
   localparam logic [MAG_W-1:0]     MAG_LIMIT           = 17'd65536;

   // Controller to datapath commands
   typedef struct packed {
      logic write_point;
      logic start_query;
      logic scan_issue;
      logic latch_target;
      logic load_row;
      logic last_row;
   } pnpr_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } pnpr_status_type;

endpackage

>>> src/pnpr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnpr_ctrl
// Sequencer of the block: takes request transactions, steps the scan
// address over the path, waits for the distance pipeline to drain and
// walks the horizon rows into the response register.
// ----------------------------------------------------------------------------
module pnpr_ctrl #(
   parameter int unsigned LW = 11,
   parameter int unsigned KW = 3,
   parameter int unsigned HORIZON = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_operation,
   output logic                     req_tready,
   input  logic [LW-1:0]            len,
   input  pnpr_pkg::pnpr_status_type status,
   output pnpr_pkg::pnpr_cmd_type   cmd,
   output logic [LW-1:0]            scan_idx,
   output logic [KW-1:0]            row_idx
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_FETCH = 5'b01000,
      ST_LOAD  = 5'b10000
   } pnpr_state_type;

   pnpr_state_type state_ff, state_in;
   logic [LW-1:0]  scan_ff, scan_in;
   logic [KW-1:0]  row_ff, row_in;
   logic           row_last;

   assign scan_idx = scan_ff;
   assign row_idx  = row_ff;
   assign row_last = (row_ff == KW'(HORIZON - 1));

   // Next state and command decode
   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      row_in     = row_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_operation == pnpr_pkg::OP_QUERY) begin
                  cmd.start_query = 1'b1;
                  scan_in         = '0;
                  state_in        = ST_SCAN;
               end else begin
                  cmd.write_point = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (scan_ff == len - LW'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + LW'(1);
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               cmd.latch_target = 1'b1;
               row_in           = '0;
               state_in         = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_row = 1'b1;
               cmd.last_row = row_last;
               if (row_last) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + KW'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         row_ff   <= row_in;
      end
   end

endmodule

>>> src/pnpr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnpr_datapath
// Path stores, squared distance pipeline with running nearest search,
// target index register, horizon row addressing and response register.
// ----------------------------------------------------------------------------
module pnpr_datapath #(
   parameter int unsigned PATH_DEPTH = 1024,
   parameter int unsigned LW = 11,
   parameter int unsigned KW = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pnpr_pkg::pnpr_cmd_type             cmd,
   output pnpr_pkg::pnpr_status_type          status,
   input  logic [LW-1:0]                      scan_idx,
   input  logic [KW-1:0]                      row_idx,
   input  logic [LW-1:0]                      len,
   input  logic [pnpr_pkg::MAG_W-1:0]         mag,
   input  logic [pnpr_pkg::INDEX_W-1:0]       point_index,
   input  logic signed [pnpr_pkg::COORD_W-1:0] point_x,
   input  logic signed [pnpr_pkg::COORD_W-1:0] point_y,
   input  logic signed [pnpr_pkg::COORD_W-1:0] point_yaw,
   input  logic signed [pnpr_pkg::COORD_W-1:0] point_speed,
   input  logic signed [pnpr_pkg::COORD_W-1:0] vehicle_x,
   input  logic signed [pnpr_pkg::COORD_W-1:0] vehicle_y,
   input  logic [pnpr_pkg::INDEX_W-1:0]       previous_index,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic                               rsp_last,
   output logic signed [pnpr_pkg::COORD_W-1:0] ref_x,
   output logic signed [pnpr_pkg::COORD_W-1:0] ref_y,
   output logic signed [pnpr_pkg::COORD_W-1:0] ref_speed,
   output logic signed [pnpr_pkg::COORD_W-1:0] ref_yaw,
   output logic signed [pnpr_pkg::ACCEL_W-1:0] accel_ref,
   output logic [pnpr_pkg::INDEX_W-1:0]       target_index
);

   localparam int unsigned CW = pnpr_pkg::COORD_W;
   localparam int unsigned AW = $clog2(PATH_DEPTH);
   localparam int unsigned TW = (LW > pnpr_pkg::INDEX_W) ? LW : pnpr_pkg::INDEX_W;
   localparam int unsigned IW = TW + 1;
   localparam int unsigned SQ_W = 2 * CW;
   localparam int unsigned DIST_W = SQ_W + 1;

   // Path stores
   logic [CW-1:0] x_mem     [PATH_DEPTH];
   logic [CW-1:0] y_mem     [PATH_DEPTH];
   logic [CW-1:0] yaw_mem   [PATH_DEPTH];
   logic [CW-1:0] speed_mem [PATH_DEPTH];

   logic [CW-1:0] rd_x_ff, rd_y_ff, rd_yaw_ff, rd_speed_ff;
   logic [AW-1:0] raddr;
   logic          wr_in_range;

   // Query registers
   logic signed [CW-1:0]          veh_x_ff, veh_y_ff;
   logic [pnpr_pkg::INDEX_W-1:0]  prev_ff;
   logic [TW-1:0]                 target_ff, target_in;

   // Distance pipeline
   logic          s1_v_ff, s2_v_ff, s3_v_ff;
   logic          s1_first_ff, s2_first_ff, s3_first_ff;
   logic [LW-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic signed [CW:0] dx, dy;
   logic [CW-1:0] dx_abs, dy_abs;
   logic [CW-1:0] dx_abs_ff, dy_abs_ff;
   logic [SQ_W-1:0] sq_x_ff, sq_y_ff;
   logic [DIST_W-1:0] dist_sum;
   logic [DIST_W-1:0] best_dist_ff;
   logic [LW-1:0]     best_idx_ff;
   logic              best_take;

   // Row addressing
   logic [IW-1:0] row_sum, len_ext, row_addr;

   // Response register
   logic          rsp_valid_ff;
   logic [CW-1:0] out_x_ff, out_y_ff, out_speed_ff, out_yaw_ff;
   logic [pnpr_pkg::ACCEL_W-1:0] out_accel_ff, accel_in;
   logic [pnpr_pkg::INDEX_W-1:0] out_tgt_ff;
   logic          out_last_ff;

   assign wr_in_range = (32'(point_index) < PATH_DEPTH);

   // Horizon row address, clamped to the last valid point
   always_comb begin
      row_sum = IW'(target_ff) + IW'(row_idx) + IW'(1);
      len_ext = IW'(len);
      if (row_sum >= len_ext) begin
         row_addr = len_ext - IW'(1);
      end else begin
         row_addr = row_sum;
      end
      raddr = cmd.scan_issue ? AW'(scan_idx) : AW'(row_addr);
   end

   // Write one point, read all four stores at the shared address
   always_ff @(posedge clock) begin
      if (cmd.write_point && wr_in_range) begin
         x_mem[AW'(point_index)]     <= point_x;
         y_mem[AW'(point_index)]     <= point_y;
         yaw_mem[AW'(point_index)]   <= point_yaw;
         speed_mem[AW'(point_index)] <= point_speed;
      end
      rd_x_ff     <= x_mem[raddr];
      rd_y_ff     <= y_mem[raddr];
      rd_yaw_ff   <= yaw_mem[raddr];
      rd_speed_ff <= speed_mem[raddr];
   end

   // Latch query fields and the target index
   assign target_in = (TW'(best_idx_ff) > TW'(prev_ff)) ? TW'(best_idx_ff) : TW'(prev_ff);

   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         veh_x_ff <= vehicle_x;
         veh_y_ff <= vehicle_y;
         prev_ff  <= previous_index;
      end
      if (cmd.latch_target) begin
         target_ff <= target_in;
      end
   end

   // Absolute coordinate differences, distance sum and nearest take decision
   always_comb begin
      dx = {veh_x_ff[CW-1], veh_x_ff} - {rd_x_ff[CW-1], rd_x_ff};
      dy = {veh_y_ff[CW-1], veh_y_ff} - {rd_y_ff[CW-1], rd_y_ff};
      dx_abs = dx[CW] ? CW'(-dx) : CW'(dx);
      dy_abs = dy[CW] ? CW'(-dy) : CW'(dy);
      dist_sum = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
      best_take = s3_v_ff && (s3_first_ff || (dist_sum < best_dist_ff));
   end

   // Advance the pipeline tags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.scan_issue;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   // Difference, square and nearest compare stages
   always_ff @(posedge clock) begin
      s1_idx_ff   <= scan_idx;
      s1_first_ff <= (scan_idx == '0);
      s2_idx_ff   <= s1_idx_ff;
      s2_first_ff <= s1_first_ff;
      dx_abs_ff   <= dx_abs;
      dy_abs_ff   <= dy_abs;
      s3_idx_ff   <= s2_idx_ff;
      s3_first_ff <= s2_first_ff;
      sq_x_ff     <= dx_abs_ff * dx_abs_ff;
      sq_y_ff     <= dy_abs_ff * dy_abs_ff;
      if (best_take) begin
         best_dist_ff <= dist_sum;
         best_idx_ff  <= s3_idx_ff;
      end
   end

   // Acceleration reference from the sign of the row speed
   assign accel_in = rd_speed_ff[CW-1] ? -{1'b0, mag} : {1'b0, mag};

   // Response register: load a row, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_row) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_row) begin
         out_x_ff     <= rd_x_ff;
         out_y_ff     <= rd_y_ff;
         out_speed_ff <= rd_speed_ff;
         out_yaw_ff   <= rd_yaw_ff;
         out_accel_ff <= accel_in;
         out_tgt_ff   <= target_ff[pnpr_pkg::INDEX_W-1:0];
         out_last_ff  <= cmd.last_row;
      end
   end

   assign status.pipe_busy = s1_v_ff || s2_v_ff || s3_v_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_last     = out_last_ff;
   assign ref_x        = out_x_ff;
   assign ref_y        = out_y_ff;
   assign ref_speed    = out_speed_ff;
   assign ref_yaw      = out_yaw_ff;
   assign accel_ref    = out_accel_ff;
   assign target_index = out_tgt_ff;

endmodule

>>> src/path_nearest_point_reference.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_nearest_point_reference
// Waypoint path store with nearest point search; answers a query with
// HORIZON reference rows following the chosen target index.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction
//  req_*     in         path point write (tuser 0) or query (tuser 1)
//  rsp_*     out        one horizon reference row, tlast on the final row
//  csr_*     in/out     course_length at 0x0, accel_ref_magnitude at 0x4
//
//  Point writes may follow back to back.
//  A query reads the stores once per path point through the shared read
//  port, waits for the distance compare pipeline to drain, then does a
//  read and a load for each row.
//  Rows wait in the output register while rsp_tready is low; the scan
//  stalls nothing but the request channel.
//  Reset is synchronous; the path stores are not cleared.
// ----------------------------------------------------------------------------
module path_nearest_point_reference #(
   parameter int unsigned PATH_DEPTH = 1024,
   parameter int unsigned HORIZON = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // point_index, point_x, point_y, point_yaw, point_speed,
   // vehicle_x, vehicle_y, previous_index, 4 bits of zero
   input  logic [pnpr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // operation
   input  logic [pnpr_pkg::REQ_TUSER_W-1:0]     req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // ref_x, ref_y, ref_speed, ref_yaw, accel_ref, target_index, 4 bits of zero
   output logic [pnpr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pnpr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pnpr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pnpr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int unsigned LEN_MAX = (PATH_DEPTH < 2047) ? PATH_DEPTH : 2047;
   localparam int unsigned LW = $clog2(LEN_MAX + 1);
   localparam int unsigned KW = (HORIZON > 1) ? $clog2(HORIZON) : 1;
   localparam int unsigned CW = pnpr_pkg::COORD_W;
   localparam int unsigned XW = pnpr_pkg::INDEX_W;

   logic [pnpr_pkg::LEN_CFG_W-1:0] course_length_ff;
   logic [pnpr_pkg::MAG_W-1:0]     accel_mag_ff;
   logic [LW-1:0]                  len_eff;
   logic [pnpr_pkg::MAG_W-1:0]     mag_eff;
   logic                           csr_write;

   pnpr_pkg::pnpr_cmd_type    cmd;
   pnpr_pkg::pnpr_status_type status;
   logic [LW-1:0]             scan_idx;
   logic [KW-1:0]             row_idx;

   logic signed [CW-1:0]      ref_x, ref_y, ref_speed, ref_yaw;
   logic signed [pnpr_pkg::ACCEL_W-1:0] accel_ref;
   logic [XW-1:0]             target_index;

   // Register writes
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         course_length_ff <= pnpr_pkg::COURSE_LENGTH_RESET;
         accel_mag_ff     <= pnpr_pkg::ACCEL_MAG_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            pnpr_pkg::CSR_IDX_COURSE_LENGTH: begin
               course_length_ff <= csr_pwdata[pnpr_pkg::LEN_CFG_W-1:0];
            end
            pnpr_pkg::CSR_IDX_ACCEL_MAG: begin
               accel_mag_ff <= csr_pwdata[pnpr_pkg::MAG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_paddr[2])
         pnpr_pkg::CSR_IDX_COURSE_LENGTH: csr_prdata = 32'(course_length_ff);
         pnpr_pkg::CSR_IDX_ACCEL_MAG:     csr_prdata = 32'(accel_mag_ff);
         default:                         csr_prdata = '0;
      endcase
   end

   // Clamp length to [1, PATH_DEPTH] and magnitude to one
   always_comb begin
      if (course_length_ff == '0) begin
         len_eff = LW'(1);
      end else if (32'(course_length_ff) > PATH_DEPTH) begin
         len_eff = LW'(PATH_DEPTH);
      end else begin
         len_eff = LW'(course_length_ff);
      end
      mag_eff = (accel_mag_ff > pnpr_pkg::MAG_LIMIT) ? pnpr_pkg::MAG_LIMIT : accel_mag_ff;
   end

   pnpr_ctrl #(
      .LW      (LW),
      .KW      (KW),
      .HORIZON (HORIZON)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_operation (req_tuser[0]),
      .req_tready    (req_tready),
      .len           (len_eff),
      .status        (status),
      .cmd           (cmd),
      .scan_idx      (scan_idx),
      .row_idx       (row_idx)
   );

   pnpr_datapath #(
      .PATH_DEPTH (PATH_DEPTH),
      .LW         (LW),
      .KW         (KW)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .scan_idx       (scan_idx),
      .row_idx        (row_idx),
      .len            (len_eff),
      .mag            (mag_eff),
      .point_index    (req_tdata[pnpr_pkg::REQ_IDX_LSB +: XW]),
      .point_x        (req_tdata[pnpr_pkg::REQ_PX_LSB +: CW]),
      .point_y        (req_tdata[pnpr_pkg::REQ_PY_LSB +: CW]),
      .point_yaw      (req_tdata[pnpr_pkg::REQ_PYAW_LSB +: CW]),
      .point_speed    (req_tdata[pnpr_pkg::REQ_PSPD_LSB +: CW]),
      .vehicle_x      (req_tdata[pnpr_pkg::REQ_VX_LSB +: CW]),
      .vehicle_y      (req_tdata[pnpr_pkg::REQ_VY_LSB +: CW]),
      .previous_index (req_tdata[pnpr_pkg::REQ_PREV_LSB +: XW]),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_last       (rsp_tlast),
      .ref_x          (ref_x),
      .ref_y          (ref_y),
      .ref_speed      (ref_speed),
      .ref_yaw        (ref_yaw),
      .accel_ref      (accel_ref),
      .target_index   (target_index)
   );

   // Pack the response row
   assign rsp_tdata = {4'b0, target_index, accel_ref, ref_yaw, ref_speed, ref_y, ref_x};

endmodule

>>> src/pnpr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnpr_checker
// Port-level checks of the nearest path point reference block, bound to
// the top level.
// ----------------------------------------------------------------------------
module pnpr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic [pnpr_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [pnpr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready
);

   localparam int unsigned ACC_MSB = pnpr_pkg::RSP_ACC_LSB + pnpr_pkg::ACCEL_W - 1;
   localparam int unsigned TGT_MSB = pnpr_pkg::RSP_TGT_LSB + pnpr_pkg::INDEX_W - 1;
   localparam int unsigned SPD_MSB = pnpr_pkg::RSP_SPD_LSB + pnpr_pkg::COORD_W - 1;

   // A stalled row holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response row changed");

   // A query blocks the request channel while the path is scanned
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == pnpr_pkg::OP_QUERY) |=> !req_tready)
      else $error("request accepted during scan");

   // A point write leaves the block ready for the next one
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == pnpr_pkg::OP_WRITE) |=> req_tready)
      else $error("point write stalled the request channel");

   // Target index is constant within one horizon
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |=>
         rsp_tdata[TGT_MSB:pnpr_pkg::RSP_TGT_LSB] ==
         $past(rsp_tdata[TGT_MSB:pnpr_pkg::RSP_TGT_LSB]))
      else $error("target index changed inside a horizon");

   // Acceleration sign follows the speed sign
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[SPD_MSB] ?
            (rsp_tdata[ACC_MSB] || (rsp_tdata[ACC_MSB:pnpr_pkg::RSP_ACC_LSB] == '0)) :
            !rsp_tdata[ACC_MSB]))
      else $error("acceleration reference sign mismatch");

endmodule

bind path_nearest_point_reference pnpr_checker u_pnpr_checker (.*);
